// ===== hdl/cesd_pkg.sv =====
// ----------------------------------------------------------------------------
// cesd_pkg: shared types and constants for the escape sequence decoder
// Holds the decode modes, the decoder state record and the result record.
// ----------------------------------------------------------------------------
package cesd_pkg;

	localparam int MAX_RES    = 2;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = PTR_W + 1;

	// Characters with a special role in the escaped text
	localparam logic [7:0] CH_BSLASH = 8'd92;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LF     = 8'h66;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_V      = 8'h76;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_A      = 8'h61;

	// Control codes for the named escapes
	localparam logic [7:0] CC_NL  = 8'd10;
	localparam logic [7:0] CC_TAB = 8'd9;
	localparam logic [7:0] CC_VT  = 8'd11;
	localparam logic [7:0] CC_BS  = 8'd8;
	localparam logic [7:0] CC_CR  = 8'd13;
	localparam logic [7:0] CC_FF  = 8'd12;
	localparam logic [7:0] CC_BEL = 8'd7;

	localparam logic [15:0] UNI_MAX = 16'h00ff;

	typedef enum logic [2:0] {
		MODE_PLAIN  = 3'd0,
		MODE_ESC    = 3'd1,
		MODE_XSTART = 3'd2,
		MODE_HEX    = 3'd3,
		MODE_OCT    = 3'd4,
		MODE_UNI    = 3'd5,
		MODE_SKIP   = 3'd6
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] value;
		logic [2:0]  count;
	} core_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       has_char;
		logic       bad_escape;
		logic       string_done;
		logic       run_last;
	} result_t;

	typedef struct packed {
		logic [1:0]         n;
		result_t [MAX_RES-1:0] r;
	} step_out_t;

endpackage

// ===== hdl/c_escape_sequence_decoder.sv =====
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder: streaming C escape sequence decoder
// Takes escaped text one byte a transfer and gives decoded bytes, with error
// and end-of-string marks.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  -------------------------------------
//  in       sink       in_valid/in_ready    in_byte, end_of_string
//  out      source     out_valid/out_ready  out_byte, has_char, bad_escape,
//                                           string_done, run_last
//
// One input byte per cycle is taken while the queue has room. A byte sits in the
// input register, where the decode step runs against the decoder state and drops
// zero, one or two results into a four-entry output queue.
// A held byte leaves the input register only while the queue has room for two results.
// A byte passes through the input register and then the queue to reach the output.
// Reset (arst_n low) empties the input register and the queue and returns the
// decoder to plain text mode.
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder import cesd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       has_char,
	output logic       bad_escape,
	output logic       string_done,
	output logic       run_last
);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;

	// Decoder state
	core_state_t state_q;
	core_state_t state_nxt;
	step_out_t   step_res;

	// Output queue
	result_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   wr_ptr_nx;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   add_cnt;
	logic               consume;
	logic               pop;
	result_t            head;

	// Decode the held byte once the queue can take a full pair of results
	assign consume  = valid_s1 && (count_q <= CNT_W'(FIFO_DEPTH - MAX_RES));
	assign in_ready = !valid_s1 || consume;
	assign pop      = out_valid && out_ready;
	assign add_cnt  = consume ? CNT_W'(step_res.n) : '0;
	assign wr_ptr_nx = wr_ptr_q + PTR_W'(1);

	cesd_step u_step (
		.state_cur     (state_q),
		.in_byte       (byte_s1),
		.end_of_string (eos_s1),
		.state_nxt     (state_nxt),
		.results       (step_res)
	);

	// Control: input register valid, decoder state, queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '{mode: MODE_PLAIN, value: '0, count: '0};
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (consume) begin
				state_q  <= state_nxt;
				wr_ptr_q <= wr_ptr_q + PTR_W'(step_res.n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + add_cnt - CNT_W'(pop);
		end
	end

	// Payload: input byte and queue entries
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			eos_s1  <= end_of_string;
		end
		if (consume && step_res.n != 2'd0) begin
			mem_q[wr_ptr_q] <= step_res.r[0];
		end
		if (consume && step_res.n == 2'd2) begin
			mem_q[wr_ptr_nx] <= step_res.r[1];
		end
	end

	// Present the queue head
	assign head        = mem_q[rd_ptr_q];
	assign out_valid   = (count_q != '0);
	assign out_byte    = head.data;
	assign has_char    = head.has_char;
	assign bad_escape  = head.bad_escape;
	assign string_done = head.string_done;
	assign run_last    = head.run_last;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("output queue count exceeds its depth");

	a_eos_resets: assert property (@(posedge clk) disable iff (!arst_n)
		consume && eos_s1 |=> state_q.mode == MODE_PLAIN && state_q.count == '0)
		else $error("decoder state not cleared after end of string");

	a_bad_marks: assert property (@(posedge clk) disable iff (!arst_n)
		pop && bad_escape |-> string_done && !has_char && run_last)
		else $error("error result lacks end marks");

	a_skip_silent: assert property (@(posedge clk) disable iff (!arst_n)
		consume && state_q.mode == MODE_SKIP && !eos_s1 |-> step_res.n == 2'd0)
		else $error("result produced while skipping an aborted string");
`endif

endmodule

// ===== hdl/cesd_step.sv =====
// ----------------------------------------------------------------------------
// cesd_step: one-byte decode step
// Combinational: from the current state and one byte, gives the next state
// and up to two results.
// ----------------------------------------------------------------------------
module cesd_step import cesd_pkg::*; (
	input  core_state_t state_cur,
	input  logic [7:0]  in_byte,
	input  logic        end_of_string,
	output core_state_t state_nxt,
	output step_out_t   results
);

	typedef struct packed {
		core_state_t st;
		logic        aborted;
		step_out_t   o;
	} work_t;

	function automatic work_t f_put(work_t w, logic [7:0] b, logic ch, logic bad);
		work_t r;
		r = w;
		if (r.o.n < 2'd2) begin
			r.o.r[r.o.n[0]] = '{data: b, has_char: ch, bad_escape: bad,
				string_done: bad, run_last: 1'b0};
			r.o.n = r.o.n + 2'd1;
		end
		return r;
	endfunction

	function automatic work_t f_clear(work_t w);
		work_t r;
		r = w;
		r.st.value = '0;
		r.st.count = '0;
		return r;
	endfunction

	function automatic work_t f_abort(work_t w);
		work_t r;
		r = f_put(w, 8'd0, 1'b0, 1'b1);
		r.aborted = 1'b1;
		r.st.mode = MODE_SKIP;
		return f_clear(r);
	endfunction

	function automatic work_t f_plain(work_t w, logic [7:0] c);
		work_t r;
		r = w;
		if (c == CH_BSLASH) begin
			r.st.mode = MODE_ESC;
		end else begin
			r = f_put(r, c, 1'b1, 1'b0);
			r.st.mode = MODE_PLAIN;
		end
		return r;
	endfunction

	function automatic work_t f_finish_hex(work_t w);
		work_t r;
		r = w;
		if (r.st.value[7:0] == 8'd0) begin
			r = f_abort(r);
		end else begin
			r = f_put(r, r.st.value[7:0], 1'b1, 1'b0);
			r.st.mode = MODE_PLAIN;
			r = f_clear(r);
		end
		return r;
	endfunction

	function automatic logic [7:0] f_named(logic [7:0] c);
		logic [7:0] v;
		case (c)
			CH_N:    v = CC_NL;
			CH_T:    v = CC_TAB;
			CH_V:    v = CC_VT;
			CH_B:    v = CC_BS;
			CH_R:    v = CC_CR;
			CH_F:    v = CC_FF;
			CH_A:    v = CC_BEL;
			default: v = c;
		endcase
		return v;
	endfunction

	logic       hex_ok;
	logic [3:0] hex_d;
	logic       oct_ok;
	work_t      w;

	always_comb begin
		hex_ok = 1'b1;
		hex_d  = in_byte[3:0];
		if (in_byte >= CH_ZERO && in_byte <= CH_NINE) begin
			hex_d = in_byte[3:0];
		end else if ((in_byte >= CH_LA && in_byte <= CH_LF) ||
			(in_byte >= CH_UA && in_byte <= CH_UF)) begin
			hex_d = in_byte[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign oct_ok = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);

	always_comb begin
		w.st      = state_cur;
		w.aborted = 1'b0;
		w.o       = '0;

		case (state_cur.mode)
			MODE_ESC: begin
				if (in_byte == CH_X) begin
					w.st.mode = MODE_XSTART;
				end else if (in_byte == CH_U) begin
					w.st.mode = MODE_UNI;
					w = f_clear(w);
				end else if (oct_ok) begin
					w.st.value = {13'd0, in_byte[2:0]};
					w.st.count = 3'd1;
					w.st.mode  = MODE_OCT;
				end else begin
					w = f_put(w, f_named(in_byte), 1'b1, 1'b0);
					w.st.mode = MODE_PLAIN;
				end
			end
			MODE_XSTART: begin
				if (hex_ok) begin
					w.st.value = {12'd0, hex_d};
					w.st.count = 3'd1;
					w.st.mode  = MODE_HEX;
				end else begin
					w = f_put(w, CH_X, 1'b1, 1'b0);
					w = f_plain(w, in_byte);
				end
			end
			MODE_HEX: begin
				if (hex_ok) begin
					w.st.value = {8'd0, w.st.value[3:0], hex_d};
					w = f_finish_hex(w);
				end else begin
					w = f_finish_hex(w);
					if (!w.aborted) begin
						w = f_plain(w, in_byte);
					end
				end
			end
			MODE_OCT: begin
				if (oct_ok) begin
					w.st.value = {5'd0, w.st.value[7:0], in_byte[2:0]};
					w.st.count = w.st.count + 3'd1;
					if (w.st.count >= 3'd3) begin
						w = f_put(w, w.st.value[7:0], 1'b1, 1'b0);
						w.st.mode = MODE_PLAIN;
						w = f_clear(w);
					end
				end else begin
					w = f_put(w, w.st.value[7:0], 1'b1, 1'b0);
					w = f_clear(w);
					w = f_plain(w, in_byte);
				end
			end
			MODE_UNI: begin
				if (!hex_ok) begin
					w = f_abort(w);
				end else begin
					w.st.value = {w.st.value[11:0], hex_d};
					w.st.count = w.st.count + 3'd1;
					if (w.st.count >= 3'd4) begin
						if (w.st.value == 16'd0 || w.st.value > UNI_MAX) begin
							w = f_abort(w);
						end else begin
							w = f_put(w, w.st.value[7:0], 1'b1, 1'b0);
							w.st.mode = MODE_PLAIN;
							w = f_clear(w);
						end
					end
				end
			end
			MODE_SKIP: begin
			end
			default: begin
				w = f_plain(w, in_byte);
			end
		endcase

		// Flush a pending escape at the end of the string and mark the last result done
		if (end_of_string && !w.aborted && state_cur.mode != MODE_SKIP) begin
			case (w.st.mode)
				MODE_XSTART: w = f_put(w, CH_X, 1'b1, 1'b0);
				MODE_HEX:    w = f_finish_hex(w);
				MODE_OCT:    w = f_put(w, w.st.value[7:0], 1'b1, 1'b0);
				MODE_UNI:    w = f_abort(w);
				default:     begin end
			endcase
			if (!w.aborted) begin
				if (w.o.n == 2'd0) begin
					w = f_put(w, 8'd0, 1'b0, 1'b0);
				end
				w.o.r[w.o.n[1]].string_done = 1'b1;
			end
		end

		if (end_of_string) begin
			w.st.mode = MODE_PLAIN;
			w = f_clear(w);
		end

		if (w.o.n != 2'd0) begin
			w.o.r[w.o.n[1]].run_last = 1'b1;
		end
	end

	assign state_nxt = w.st;
	assign results   = w.o;

endmodule

// ===== test/c_escape_sequence_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder_tb: self-checking bench for the escape decoder
// Streams escaped strings into the decoder and checks every decoded result.
// A built-in behavioral decoder predicts the results of each input transfer.
// Both sides of the block idle at random, and the receiver stalls once for a long hold-off.
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder_tb;
	import cesd_pkg::*;

	localparam int RAND_ITEMS = 1750;   // random input bytes after the directed strings
	localparam int STALL_LEN  = 300;    // long receiver hold-off, in cycles
	localparam int TAIL_LEN   = 8;      // settle time after the last result
	localparam int TIMEOUT_NS = 400_000;
	localparam int MAX_REPORT = 10;

	// Traffic shaping: who idles how often, chosen by progress through the input
	typedef enum logic [1:0] {
		PH_SPARSE_IN,    // sender idles 34 %, receiver 68 %
		PH_SPARSE_OUT,   // sender idles 68 %, receiver 34 %
		PH_FULL          // neither side idles
	} traffic_t;

	typedef logic [7:0] text_q_t[$];

	// One pending input byte; hold makes the sender wait until all results are in
	typedef struct packed {
		logic [7:0] data;
		logic       eos;
		logic       hold;
	} feed_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h20;
	logic       end_of_string = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       has_char;
	logic       bad_escape;
	logic       string_done;
	logic       run_last;

	feed_t    feed_q[$];
	result_t  want_q[$];
	logic     want_empty = 1'b1;
	traffic_t phase = PH_SPARSE_IN;
	int       stall_left = 0;
	logic     stall_fired = 1'b0;

	int sent_cnt = 0;
	int quiet_cycles = 0;
	int strings_seen = 0;
	int bad_seen = 0;
	int checked_cnt = 0;
	int mismatches = 0;

	// Behavioral decoder state
	mode_t       dec_mode = MODE_PLAIN;
	logic [15:0] dec_value = '0;
	logic [2:0]  dec_count = '0;
	result_t     step_res[MAX_RES];
	int          step_n;
	logic        step_abort;

	c_escape_sequence_decoder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.end_of_string(end_of_string),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.has_char     (has_char),
		.bad_escape   (bad_escape),
		.string_done  (string_done),
		.run_last     (run_last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Behavioral decoder
	// ------------------------------------------------------------------

	// Value of a hex digit character, -1 for anything else
	function automatic int hex_digit(logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return int'(c) - int'(CH_ZERO);
		if (c >= CH_LA && c <= CH_LF) return int'(c) - int'(CH_LA) + 10;
		if (c >= CH_UA && c <= CH_UF) return int'(c) - int'(CH_UA) + 10;
		return -1;
	endfunction

	// Named escapes map to control codes; any other character passes through
	function automatic logic [7:0] control_code(logic [7:0] c);
		case (c)
			CH_N: return CC_NL;
			CH_T: return CC_TAB;
			CH_V: return CC_VT;
			CH_B: return CC_BS;
			CH_R: return CC_CR;
			CH_F: return CC_FF;
			CH_A: return CC_BEL;
			default: return c;
		endcase
	endfunction

	// Add one result to the current step; a bad escape always ends the string
	function automatic void emit(logic [7:0] data, logic ch, logic bad);
		if (step_n < MAX_RES) begin
			step_res[step_n] = '{data, ch, bad, bad, 1'b0};
			step_n++;
		end
	endfunction

	function automatic void clear_escape();
		dec_value = '0;
		dec_count = '0;
	endfunction

	// Report the error and drop everything up to the end of the string
	function automatic void abort_string();
		emit(8'h00, 1'b0, 1'b1);
		step_abort = 1'b1;
		dec_mode = MODE_SKIP;
		clear_escape();
	endfunction

	function automatic void plain_char(logic [7:0] c);
		if (c == CH_BSLASH) begin
			dec_mode = MODE_ESC;
		end else begin
			emit(c, 1'b1, 1'b0);
			dec_mode = MODE_PLAIN;
		end
	endfunction

	// A hex escape with value zero is malformed
	function automatic void finish_hex();
		if (dec_value[7:0] == 8'h00) begin
			abort_string();
		end else begin
			emit(dec_value[7:0], 1'b1, 1'b0);
			dec_mode = MODE_PLAIN;
			clear_escape();
		end
	endfunction

	// Decode one input byte and queue the results it causes
	function automatic void decode_step(logic [7:0] c, logic eos);
		mode_t start;
		int    d;
		start = dec_mode;
		step_n = 0;
		step_abort = 1'b0;
		d = hex_digit(c);
		case (start)
			MODE_ESC: begin
				if (c == CH_X) begin
					dec_mode = MODE_XSTART;
				end else if (c == CH_U) begin
					dec_mode = MODE_UNI;
					clear_escape();
				end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
					dec_value = {13'b0, c[2:0]};
					dec_count = 3'd1;
					dec_mode = MODE_OCT;
				end else begin
					emit(control_code(c), 1'b1, 1'b0);
					dec_mode = MODE_PLAIN;
				end
			end
			MODE_XSTART: begin
				if (d >= 0) begin
					dec_value = {12'b0, d[3:0]};
					dec_count = 3'd1;
					dec_mode = MODE_HEX;
				end else begin
					// bare x: give the x, then treat this byte as text
					emit(CH_X, 1'b1, 1'b0);
					plain_char(c);
				end
			end
			MODE_HEX: begin
				if (d >= 0) begin
					dec_value = {8'h00, dec_value[3:0], d[3:0]};
					finish_hex();
				end else begin
					// digit run cut short: flush the escape, then the byte as text
					finish_hex();
					if (!step_abort) plain_char(c);
				end
			end
			MODE_OCT: begin
				if (c >= CH_ZERO && c <= CH_SEVEN) begin
					dec_value = {5'b0, dec_value[7:0], c[2:0]};
					dec_count = dec_count + 3'd1;
					if (dec_count >= 3'd3) begin
						emit(dec_value[7:0], 1'b1, 1'b0);
						dec_mode = MODE_PLAIN;
						clear_escape();
					end
				end else begin
					emit(dec_value[7:0], 1'b1, 1'b0);
					clear_escape();
					plain_char(c);
				end
			end
			MODE_UNI: begin
				if (d < 0) begin
					abort_string();
				end else begin
					dec_value = {dec_value[11:0], d[3:0]};
					dec_count = dec_count + 3'd1;
					if (dec_count >= 3'd4) begin
						if (dec_value == 16'h0000 || dec_value > UNI_MAX) begin
							abort_string();
						end else begin
							emit(dec_value[7:0], 1'b1, 1'b0);
							dec_mode = MODE_PLAIN;
							clear_escape();
						end
					end
				end
			end
			MODE_SKIP: ;
			default: plain_char(c);
		endcase

		// End of string: flush any pending escape and mark the last result
		if (eos && !step_abort && start != MODE_SKIP) begin
			case (dec_mode)
				MODE_XSTART: emit(CH_X, 1'b1, 1'b0);
				MODE_HEX:    finish_hex();
				MODE_OCT:    emit(dec_value[7:0], 1'b1, 1'b0);
				MODE_UNI:    abort_string();
				default:     ;
			endcase
			if (!step_abort) begin
				if (step_n == 0) emit(8'h00, 1'b0, 1'b0);
				step_res[step_n-1].string_done = 1'b1;
			end
		end
		if (eos) begin
			dec_mode = MODE_PLAIN;
			clear_escape();
			strings_seen++;
		end
		if (step_n > 0) step_res[step_n-1].run_last = 1'b1;
		for (int i = 0; i < step_n; i++) begin
			if (step_res[i].bad_escape) bad_seen++;
			want_q = {want_q, step_res[i]};
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	function automatic logic [7:0] hex_char(int v);
		if (v < 10) return CH_ZERO + 8'(v);
		if ($urandom_range(1) != 0) return CH_LA + 8'(v - 10);
		return CH_UA + 8'(v - 10);
	endfunction

	// Queue one string; the end flag goes on its last byte, the hold flag on its first
	task automatic queue_string(text_q_t s, bit hold);
		feed_t f;
		foreach (s[i]) begin
			f.data = s[i];
			f.eos  = (i == s.size() - 1);
			f.hold = hold && (i == 0);
			feed_q = {feed_q, f};
		end
	endtask

	task automatic queue_literal(string s);
		text_q_t t;
		for (int i = 0; i < s.len(); i++) t = {t, 8'(s[i])};
		queue_string(t, 1'b0);
	endtask

	initial begin
		text_q_t    str;
		logic [7:0] names[7];
		int         rand_bytes;
		int         kind;
		int         v;
		int         sel;
		int         ndig;
		bit         first;

		names = '{CH_N, CH_T, CH_V, CH_B, CH_R, CH_F, CH_A};
		rand_bytes = 0;
		first = 1'b1;

		// Directed strings: extreme bytes, octal zero flushed at the end,
		// trailing backslash, bare x, a hex run cut short, a full octal
		// escape, a short unicode escape, a zero hex value, a named escape
		str = {8'h01, 8'hff};
		queue_string(str, 1'b0);
		queue_literal("\\0");
		queue_literal("\\");
		queue_literal("\\xq");
		queue_literal("\\x4g");
		queue_literal("\\101");
		queue_literal("\\u1");
		queue_literal("\\x0z");
		queue_literal("\\n");

		// Random strings: mostly well-formed escapes with random content,
		// mixed with noise and broken escapes
		while (rand_bytes < RAND_ITEMS) begin
			str = {};
			repeat ($urandom_range(6, 1)) begin
				kind = $urandom_range(99);
				if (kind < 30) begin
					do v = $urandom_range(255, 1); while (v == CH_BSLASH);
					str = {str, 8'(v)};
				end else if (kind < 45) begin
					str = {str, CH_BSLASH};
					if ($urandom_range(3) == 0) str = {str, 8'($urandom_range(255, 1))};
					else str = {str, names[$urandom_range(6)]};
				end else if (kind < 57) begin
					str = {str, CH_BSLASH};
					repeat ($urandom_range(3, 1))
						str = {str, CH_ZERO + 8'($urandom_range(7))};
				end else if (kind < 70) begin
					str = {str, CH_BSLASH, CH_X};
					repeat ($urandom_range(2, 1)) begin
						if ($urandom_range(7) == 0) str = {str, CH_ZERO};
						else str = {str, hex_char($urandom_range(15))};
					end
				end else if (kind < 75) begin
					str = {str, CH_BSLASH, CH_X};
				end else if (kind < 88) begin
					str = {str, CH_BSLASH, CH_U};
					sel = $urandom_range(9);
					ndig = (sel >= 8) ? $urandom_range(3, 1) : 4;
					if (sel < 6) v = $urandom_range(255, 1);
					else if (sel == 6) v = 0;
					else if (sel == 7) v = $urandom_range(65535, 256);
					else v = $urandom_range(65535);
					for (int k = 3; k > 3 - ndig; k--) begin
						str = {str, hex_char((v >> (4 * k)) & 15)};
					end
				end else begin
					repeat ($urandom_range(3, 1)) str = {str, 8'($urandom_range(255, 1))};
				end
			end
			if ($urandom_range(9) == 0) str = {str, CH_BSLASH};
			queue_string(str, first || $urandom_range(49) == 0);
			first = 1'b0;
			rand_bytes += str.size();
		end
	end

	// ------------------------------------------------------------------
	// Reset, traffic shaping
	// ------------------------------------------------------------------

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Fire one long receiver hold-off once full-rate traffic starts, so the
	// output queue fills and the input side backs up
	always @(posedge clk) begin
		if (!stall_fired && phase == PH_FULL) begin
			stall_left <= STALL_LEN;
			stall_fired <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end
	end

	// Receiver: drop ready at random, and for the whole hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			case (phase)
				PH_SPARSE_IN:  out_ready <= (stall_left == 0) && ($urandom_range(99) >= 68);
				PH_SPARSE_OUT: out_ready <= (stall_left == 0) && ($urandom_range(99) >= 34);
				default:       out_ready <= (stall_left == 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Driver: predict on every accepted transfer, then offer the next byte
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		int idle_pct;
		if (in_valid && in_ready) begin
			decode_step(in_byte, end_of_string);
			sent_cnt++;
		end
		// count edges with nothing offered; a held item waits on this count so
		// the monitor's empty flag has seen every prediction
		if (in_valid) quiet_cycles = 0;
		else quiet_cycles++;

		phase <= (sent_cnt < 600) ? PH_SPARSE_IN : (sent_cnt < 1200) ? PH_SPARSE_OUT : PH_FULL;
		idle_pct = (phase == PH_SPARSE_IN) ? 34 : (phase == PH_SPARSE_OUT) ? 68 : 0;

		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (feed_q.size() == 0) begin
				in_valid <= 1'b0;
			end else if (feed_q[0].hold && (quiet_cycles < 2 || !want_empty)) begin
				in_valid <= 1'b0;    // hold until every expected result is in
			end else if ($urandom_range(99) < idle_pct) begin
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				in_byte <= feed_q[0].data;
				end_of_string <= feed_q[0].eos;
				void'(feed_q.pop_front());
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compare each result transfer with the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (out_valid && out_ready) begin
			got = '{out_byte, has_char, bad_escape, string_done, run_last};
			checked_cnt++;
			if (want_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORT)
					$display("%0t: unexpected result byte=%h char=%b bad=%b done=%b last=%b",
						$realtime, got.data, got.has_char, got.bad_escape,
						got.string_done, got.run_last);
			end else begin
				want = want_q.pop_front();
				if (got.data !== want.data || got.has_char !== want.has_char ||
						got.bad_escape !== want.bad_escape ||
						got.string_done !== want.string_done ||
						got.run_last !== want.run_last) begin
					mismatches++;
					if (mismatches <= MAX_REPORT)
						$display({"%0t: result %0d byte/char/bad/done/last ",
							"expected %h %b %b %b %b, got %h %b %b %b %b"},
							$realtime, checked_cnt, want.data, want.has_char,
							want.bad_escape, want.string_done, want.run_last,
							got.data, got.has_char, got.bad_escape,
							got.string_done, got.run_last);
				end
			end
		end
		want_empty <= (want_q.size() == 0);
	end

	// ------------------------------------------------------------------
	// End of run
	// ------------------------------------------------------------------
	initial begin
		@(posedge arst_n);
		// wait for the last byte to transfer, then for its results
		while (feed_q.size() != 0 || in_valid) @(negedge clk);
		repeat (2) @(negedge clk);
		while (!want_empty) @(negedge clk);
		repeat (TAIL_LEN) @(posedge clk);
		@(negedge clk);
		if (want_q.size() != 0)
			$display("%0d expected results never arrived", want_q.size());
		$display("covered %0d input transfers in %0d strings, %0d results checked",
			sent_cnt, strings_seen, checked_cnt);
		$display("%0d bad escapes, one %0d-cycle receiver hold-off, %0d mismatches",
			bad_seen, STALL_LEN, mismatches);
		if (mismatches == 0 && want_q.size() == 0)
			$display("c_escape_sequence_decoder regression: pass");
		else
			$display("c_escape_sequence_decoder regression: fail");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d bytes unsent and %0d results outstanding",
			feed_q.size(), want_q.size());
		$display("c_escape_sequence_decoder regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/cesd_pkg.sv
hdl/cesd_step.sv
hdl/c_escape_sequence_decoder.sv
test/c_escape_sequence_decoder_tb.sv
